/* hw/rtl/qpr_pkg.sv */
// ----------------------------------------------------------------------------
// qpr_pkg
// Widths and helpers shared by the quaternion point rotation block.
// ----------------------------------------------------------------------------
package qpr_pkg;

  localparam int CoordWidth = 32;
  localparam int QuatWidth  = 16;

  // Product of a quaternion component and a coordinate.
  localparam int ProdWidth  = CoordWidth + QuatWidth;
  // Component of a = q * p (sum of three products).
  localparam int AWidth     = ProdWidth + 2;
  // Product of a component of a and a quaternion component.
  localparam int MWidth     = AWidth + QuatWidth;
  // Vector component of N = a * conj(q) (sum of four products).
  localparam int NWidth     = MWidth + 2;
  // Squared norm, unsigned.
  localparam int NormWidth  = 2 * QuatWidth + 1;
  // Rounding dividend 2|N| + n.
  localparam int DivWidth   = NWidth + 2;
  // Divisor 2n.
  localparam int DenWidth   = NormWidth + 1;
  // Quotient bits; the rotated point never exceeds sqrt(3) times full scale.
  localparam int QuoBits    = CoordWidth + 2;
  localparam int StepWidth  = DenWidth + QuoBits;

  localparam logic [1:0] RegQuatW = 2'd0;
  localparam logic [1:0] RegQuatX = 2'd1;
  localparam logic [1:0] RegQuatY = 2'd2;
  localparam logic [1:0] RegQuatZ = 2'd3;

  localparam logic [QuatWidth-1:0] QuatOne = QuatWidth'(1) << (QuatWidth - 3);

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [QuatWidth-1:0]  quat_t;

  // One restoring division step: the upper DenWidth bits hold the partial
  // remainder, the lower bits hold the dividend bits still to come and
  // collect the quotient from the bottom.
  function automatic logic [StepWidth-1:0] div_step(input logic [StepWidth-1:0] s,
                                                     input logic [DenWidth-1:0] den);
    logic [DenWidth:0] t;
    logic [DenWidth:0] r;
    logic              ge;
    t  = {s[StepWidth-1:QuoBits], s[QuoBits-1]};
    ge = (t >= {1'b0, den});
    r  = ge ? (t - {1'b0, den}) : t;
    return {r[DenWidth-1:0], s[QuoBits-2:0], ge};
  endfunction

endpackage

/* hw/rtl/qpr_point_if.sv */
// ----------------------------------------------------------------------------
// qpr_point_if
// Input channel carrying one 3-D point per transaction.
// ----------------------------------------------------------------------------
interface qpr_point_if;
  import qpr_pkg::*;

  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  coord_t point_z;

  modport source (output valid, output point_x, output point_y, output point_z,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z,
                  output ready);
endinterface

/* hw/rtl/qpr_result_if.sv */
// ----------------------------------------------------------------------------
// qpr_result_if
// Output channel carrying one rotated point and its flags per transaction.
// ----------------------------------------------------------------------------
interface qpr_result_if;
  import qpr_pkg::*;

  logic   valid;
  logic   ready;
  coord_t rotated_x;
  coord_t rotated_y;
  coord_t rotated_z;
  logic   saturated;
  logic   zero_norm;

  modport source (output valid, output rotated_x, output rotated_y, output rotated_z,
                  output saturated, output zero_norm, input ready);
  modport sink   (input valid, input rotated_x, input rotated_y, input rotated_z,
                  input saturated, input zero_norm, output ready);
endinterface

/* hw/rtl/quaternion_point_rotation.sv */
// ----------------------------------------------------------------------------
// quaternion_point_rotation
// Rotates points by the configured quaternion, computing q * p * conj(q) / |q|^2
// with exact integer products and a pipelined restoring divider.
// ----------------------------------------------------------------------------
//
//  channel  | direction | transaction contents
//  ---------+-----------+-----------------------------------------------------
//  point    | in        | point_x, point_y, point_z (signed Q16.16)
//  result   | out       | rotated_x/y/z (signed Q16.16), saturated, zero_norm
//  cfg      | in        | cfg_we, cfg_index, cfg_data (quat_w, x, y, z)
//
// One point enters per cycle while the result side is not stalled; the
// pipeline holds the 34 one-bit steps of the restoring divider, each
// with a register stage of its own, plus five product/sum stages and the
// output register.
// Reset clears every valid bit and loads the identity quaternion.
// A stall on the result side freezes the whole pipeline in place, so no
// transaction is lost or repeated; ready follows that shared enable.
// The squared norm is registered from the quaternion registers through the square
// and sum registers, and settles before a point entering after a write reaches the divider.
module quaternion_point_rotation (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [qpr_pkg::QuatWidth-1:0]   cfg_data,
  qpr_point_if.sink                       point,
  qpr_result_if.source                    result
);
  import qpr_pkg::*;

  // Configuration registers.
  quat_t qw, qx, qy, qz;

  always_ff @(posedge clk) begin
    if (rst) begin
      qw <= QuatOne;
      qx <= '0;
      qy <= '0;
      qz <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegQuatW: qw <= cfg_data;
        RegQuatX: qx <= cfg_data;
        RegQuatY: qy <= cfg_data;
        RegQuatZ: qz <= cfg_data;
        default: ;
      endcase
    end
  end

  // Squared norm: squares in one register, their sum in the next.
  logic signed [2*QuatWidth-1:0] sq_w, sq_x, sq_y, sq_z;
  logic [NormWidth-1:0]          norm;

  always_ff @(posedge clk) begin
    sq_w <= (2*QuatWidth)'(qw * qw);
    sq_x <= (2*QuatWidth)'(qx * qx);
    sq_y <= (2*QuatWidth)'(qy * qy);
    sq_z <= (2*QuatWidth)'(qz * qz);
    norm <= NormWidth'(sq_w) + NormWidth'(sq_x) + NormWidth'(sq_y) + NormWidth'(sq_z);
  end

  // The whole pipeline moves together whenever the output register can take data.
  logic adv;
  assign adv         = !result.valid || result.ready;
  assign point.ready = adv;

  // Stage 1: the twelve products of q * p.
  logic v1;
  logic signed [ProdWidth-1:0] wpx, ypz, zpy, wpy, zpx, xpz, wpz, xpy, ypx, xpx, ypy, zpz;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= point.valid;
    if (adv) begin
      wpx <= ProdWidth'(qw * point.point_x);
      ypz <= ProdWidth'(qy * point.point_z);
      zpy <= ProdWidth'(qz * point.point_y);
      wpy <= ProdWidth'(qw * point.point_y);
      zpx <= ProdWidth'(qz * point.point_x);
      xpz <= ProdWidth'(qx * point.point_z);
      wpz <= ProdWidth'(qw * point.point_z);
      xpy <= ProdWidth'(qx * point.point_y);
      ypx <= ProdWidth'(qy * point.point_x);
      xpx <= ProdWidth'(qx * point.point_x);
      ypy <= ProdWidth'(qy * point.point_y);
      zpz <= ProdWidth'(qz * point.point_z);
    end
  end

  // Stage 2: a = q * p.
  logic v2;
  logic signed [AWidth-1:0] aw, ax, ay, az;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
    if (adv) begin
      aw <= -(AWidth'(xpx) + AWidth'(ypy) + AWidth'(zpz));
      ax <= AWidth'(wpx) + AWidth'(ypz) - AWidth'(zpy);
      ay <= AWidth'(wpy) + AWidth'(zpx) - AWidth'(xpz);
      az <= AWidth'(wpz) + AWidth'(xpy) - AWidth'(ypx);
    end
  end

  // Stage 3: the twelve products of a * conj(q) that feed the vector part.
  logic v3;
  logic signed [MWidth-1:0] axw, awx, azy, ayz, ayw, awy, axz, azx, azw, awz, ayx, axy;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
    if (adv) begin
      axw <= MWidth'(ax * qw);
      awx <= MWidth'(aw * qx);
      azy <= MWidth'(az * qy);
      ayz <= MWidth'(ay * qz);
      ayw <= MWidth'(ay * qw);
      awy <= MWidth'(aw * qy);
      axz <= MWidth'(ax * qz);
      azx <= MWidth'(az * qx);
      azw <= MWidth'(az * qw);
      awz <= MWidth'(aw * qz);
      ayx <= MWidth'(ay * qx);
      axy <= MWidth'(ax * qy);
    end
  end

  // Stage 4: vector part of N.
  logic v4;
  logic signed [NWidth-1:0] nv [3];

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= v3;
    if (adv) begin
      nv[0] <= NWidth'(axw) - NWidth'(awx) + NWidth'(azy) - NWidth'(ayz);
      nv[1] <= NWidth'(ayw) - NWidth'(awy) + NWidth'(axz) - NWidth'(azx);
      nv[2] <= NWidth'(azw) - NWidth'(awz) + NWidth'(ayx) - NWidth'(axy);
    end
  end

  // Stage 5 loads the divider: the dividend 2|N| + n gives round half away
  // from zero once divided by 2n. Entry 0 of the divider arrays is stage 5.
  logic                 dv   [QuoBits+1];
  logic                 dzn  [QuoBits+1];
  logic [2:0]           dneg [QuoBits+1];
  logic [StepWidth-1:0] dst  [QuoBits+1][3];
  logic [DenWidth-1:0]  den;
  logic [NWidth-1:0]    mag  [3];
  logic [DivWidth-1:0]  dvd  [3];

  assign den = {norm, 1'b0};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mag[c] = nv[c][NWidth-1] ? NWidth'(-nv[c]) : NWidth'(nv[c]);
      dvd[c] = {1'b0, mag[c], 1'b0} + DivWidth'(norm);
    end
  end

  // Divider: one quotient bit per stage for each of the three coordinates.
  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else if (adv) dv[0] <= v4;
    if (adv) begin
      dzn[0] <= (norm == '0);
      for (int c = 0; c < 3; c++) begin
        dneg[0][c] <= nv[c][NWidth-1];
        dst[0][c]  <= dvd[c][StepWidth-1:0];
      end
    end
    for (int k = 1; k <= QuoBits; k++) begin
      if (rst) dv[k] <= 1'b0;
      else if (adv) dv[k] <= dv[k-1];
      if (adv) begin
        dzn[k]  <= dzn[k-1];
        dneg[k] <= dneg[k-1];
        for (int c = 0; c < 3; c++) begin
          dst[k][c] <= div_step(dst[k-1][c], den);
        end
      end
    end
  end

  // Output register: restore the sign and saturate.
  logic [QuoBits-1:0] quo     [3];
  logic [2:0]         clip;
  coord_t             coord   [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      quo[c] = dst[QuoBits][c][QuoBits-1:0];
      if (dneg[QuoBits][c]) begin
        // The most negative value is the one magnitude past the positive limit.
        clip[c]  = (quo[c] > (QuoBits'(1) << (CoordWidth - 1)));
        coord[c] = clip[c] ? {1'b1, {(CoordWidth-1){1'b0}}} : CoordWidth'(-quo[c]);
      end else begin
        clip[c]  = (quo[c][QuoBits-1:CoordWidth-1] != '0);
        coord[c] = clip[c] ? {1'b0, {(CoordWidth-1){1'b1}}} : CoordWidth'(quo[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) result.valid <= 1'b0;
    else if (adv) result.valid <= dv[QuoBits];
    if (adv) begin
      result.zero_norm <= dzn[QuoBits];
      result.saturated <= !dzn[QuoBits] && (clip != '0);
      result.rotated_x <= dzn[QuoBits] ? '0 : coord[0];
      result.rotated_y <= dzn[QuoBits] ? '0 : coord[1];
      result.rotated_z <= dzn[QuoBits] ? '0 : coord[2];
    end
  end

`ifndef SYNTHESIS
  // A zero quaternion must produce an all-zero, unsaturated point.
  a_zero_norm_clean: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.zero_norm |->
      result.rotated_x == '0 && result.rotated_y == '0 && result.rotated_z == '0 &&
      !result.saturated)
    else $error("zero_norm result carries nonzero data");

  // Saturation must leave at least one coordinate at a range limit.
  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.saturated |->
      result.rotated_x == {1'b0, {(CoordWidth-1){1'b1}}} ||
      result.rotated_x == {1'b1, {(CoordWidth-1){1'b0}}} ||
      result.rotated_y == {1'b0, {(CoordWidth-1){1'b1}}} ||
      result.rotated_y == {1'b1, {(CoordWidth-1){1'b0}}} ||
      result.rotated_z == {1'b0, {(CoordWidth-1){1'b1}}} ||
      result.rotated_z == {1'b1, {(CoordWidth-1){1'b0}}})
    else $error("saturated flag without a clipped coordinate");

  // While stalled, the valid bits of stage 1, stage 4 and the last divider step must not move.
  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(v1) && $stable(v4) && $stable(dv[QuoBits]))
    else $error("pipeline advanced during a stall");
`endif

endmodule

/* test/tb_quaternion_point_rotation.sv */
// ----------------------------------------------------------------------------
// tb_quaternion_point_rotation
// Self-checking testbench for the quaternion point rotation block.
// ----------------------------------------------------------------------------
// Points are pushed through the input channel while the result channel
// stalls at random. Every accepted point is rotated by a predictor that
// computes q * p * conj(q) / |q|^2 exactly at 128 bits, and every accepted
// result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_quaternion_point_rotation;
  import qpr_pkg::*;

  typedef struct {
    coord_t rx;
    coord_t ry;
    coord_t rz;
    logic   sat;
    logic   zn;
  } rotation_t;

  // Expected rotated points, plus the quaternion the block holds right now.
  class rotation_scoreboard;
    quat_t     qw, qx, qy, qz;
    rotation_t pending[$];
    int        mismatches;
    int        checked;
    int        sat_seen;
    int        zero_seen;

    function new();
      qw = QuatOne;
      qx = '0;
      qy = '0;
      qz = '0;
      mismatches = 0;
      checked = 0;
      sat_seen = 0;
      zero_seen = 0;
    endfunction

    // Divides by the norm with rounding to nearest, ties away from zero,
    // then clamps to the coordinate range.
    function automatic coord_t round_clamp(input logic signed [127:0] num,
                                           input logic [127:0] norm, inout logic sat);
      logic [127:0]        mag;
      logic signed [127:0] quo;
      logic signed [127:0] hi_lim;
      logic signed [127:0] lo_lim;
      hi_lim = (128'sd1 <<< (CoordWidth - 1)) - 1;
      lo_lim = -(hi_lim + 1);
      mag = (num < 0) ? -num : num;
      quo = ((mag << 1) + norm) / (norm << 1);
      if (num < 0) quo = -quo;
      if (quo > hi_lim) begin
        sat = 1'b1;
        quo = hi_lim;
      end else if (quo < lo_lim) begin
        sat = 1'b1;
        quo = lo_lim;
      end
      return quo[CoordWidth-1:0];
    endfunction

    function void note_point(input coord_t px, input coord_t py, input coord_t pz);
      logic signed [127:0] w, x, y, z, vx, vy, vz;
      logic signed [127:0] aw, ax, ay, az, nx, ny, nz;
      logic [127:0]        norm;
      rotation_t           r;
      w = qw; x = qx; y = qy; z = qz;
      vx = px; vy = py; vz = pz;
      norm = w * w + x * x + y * y + z * z;
      r.sat = 1'b0;
      r.zn = 1'b0;
      if (norm == 0) begin
        r.rx = '0; r.ry = '0; r.rz = '0;
        r.zn = 1'b1;
      end else begin
        aw = -(x * vx + y * vy + z * vz);
        ax = w * vx + y * vz - z * vy;
        ay = w * vy + z * vx - x * vz;
        az = w * vz + x * vy - y * vx;
        nx = ax * w - aw * x + az * y - ay * z;
        ny = ay * w - aw * y + ax * z - az * x;
        nz = az * w - aw * z + ay * x - ax * y;
        r.rx = round_clamp(nx, norm, r.sat);
        r.ry = round_clamp(ny, norm, r.sat);
        r.rz = round_clamp(nz, norm, r.sat);
      end
      pending.push_back(r);
    endfunction

    function void check_result(input rotation_t got);
      rotation_t exp;
      if (pending.size() == 0) begin
        $error("result transaction with no point outstanding");
        mismatches++;
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (got.sat) sat_seen++;
      if (got.zn) zero_seen++;
      if (got.rx !== exp.rx) begin
        $error("rotated_x: expected %0d, got %0d", exp.rx, got.rx);
        mismatches++;
      end
      if (got.ry !== exp.ry) begin
        $error("rotated_y: expected %0d, got %0d", exp.ry, got.ry);
        mismatches++;
      end
      if (got.rz !== exp.rz) begin
        $error("rotated_z: expected %0d, got %0d", exp.rz, got.rz);
        mismatches++;
      end
      if (got.sat !== exp.sat) begin
        $error("saturated: expected %0b, got %0b", exp.sat, got.sat);
        mismatches++;
      end
      if (got.zn !== exp.zn) begin
        $error("zero_norm: expected %0b, got %0b", exp.zn, got.zn);
        mismatches++;
      end
    endfunction
  endclass

  localparam int CycleLimit = 200000;
  localparam int Latency    = 40;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [1:0]           cfg_index;
  logic [QuatWidth-1:0] cfg_data;
  logic                 calm;
  int                   cycles;

  rotation_scoreboard rotations;

  qpr_point_if  point();
  qpr_result_if result();

  quaternion_point_rotation dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .point     (point.sink),
    .result    (result.source)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The result side stalls at random with a chance of 9 in 100, except while the
  // calm stretch runs at full rate.
  initial begin
    result.ready = 1'b0;
    forever begin
      @(negedge clk);
      result.ready = calm ? 1'b1 : ($urandom_range(99) >= 9);
    end
  end

  // Both channels are sampled at the rising edge; stimulus only changes at
  // the falling edge, so there is no ordering hazard between the two.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
    if (!rst) begin
      if (point.valid && point.ready)
        rotations.note_point(point.point_x, point.point_y, point.point_z);
      if (result.valid && result.ready)
        rotations.check_result('{result.rotated_x, result.rotated_y,
                                 result.rotated_z, result.saturated, result.zero_norm});
    end
  end

  // Offers one point and returns after the transaction is accepted. Valid is
  // left high so that back-to-back points keep the channel busy.
  task automatic send_point(input coord_t px, input coord_t py, input coord_t pz);
    while (!calm && $urandom_range(99) < 9) begin
      point.valid = 1'b0;
      @(negedge clk);
    end
    point.valid = 1'b1;
    point.point_x = px;
    point.point_y = py;
    point.point_z = pz;
    do @(posedge clk); while (!point.ready);
    @(negedge clk);
  endtask

  // Lets the pipeline drain; quaternion registers are only written then.
  task automatic drain();
    point.valid = 1'b0;
    while (rotations.pending.size() != 0) @(negedge clk);
    repeat (Latency + 5) @(negedge clk);
  endtask

  task automatic write_quat(input quat_t w, input quat_t x, input quat_t y, input quat_t z);
    quat_t vals[4];
    vals = '{w, x, y, z};
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_we = 1'b1;
      cfg_index = i[1:0];
      cfg_data = vals[i];
      @(negedge clk);
    end
    cfg_we = 1'b0;
    rotations.qw = w;
    rotations.qx = x;
    rotations.qy = y;
    rotations.qz = z;
    repeat (4) @(negedge clk);
  endtask

  function automatic coord_t random_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom) >>> $urandom_range(30, 8);
      2: return $urandom_range(1) ? 32'h7fffffff - $urandom_range(3)
                                  : 32'h80000000 + $urandom_range(3);
      default: return $signed($urandom_range(65535)) - 32768;
    endcase
  endfunction

  function automatic quat_t random_quat_part();
    case ($urandom_range(2))
      0: return QuatWidth'($urandom);
      1: return QuatWidth'($signed($urandom_range(16383)) - 8192);
      default: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    endcase
  endfunction

  task automatic send_extremes();
    send_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    send_point(32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_point(32'sh7fffffff, 32'sh80000000, 32'sh0);
    send_point(32'sh0, 32'sh0, 32'sh0);
    send_point(32'sh00010000, 32'shffff0000, 32'sh1);
    send_point(32'shffffffff, 32'sh00008000, 32'sh80000000);
  endtask

  initial begin
    rotations = new();
    cycles = 0;
    calm = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = RegQuatW;
    cfg_data = '0;
    point.valid = 1'b0;
    point.point_x = '0;
    point.point_y = '0;
    point.point_z = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: the identity quaternion left by reset, a quarter turn
    // about z, the zero quaternion, an unnormalized tilt that drives full
    // scale points past the range, and the register extremes.
    send_extremes();
    write_quat(16'sd5793, 16'sd0, 16'sd0, 16'sd5793);
    send_point(32'sh00010000, 32'sh0, 32'sh0);
    send_point(32'sh7fffffff, 32'sh7fffffff, 32'sh0);
    write_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_point(32'sh12345678, 32'sh80000000, 32'sh7fffffff);
    send_point(32'sh0, 32'sh0, 32'sh0);
    write_quat(16'sd3, 16'sd7, -16'sd5, 16'sd11);
    send_extremes();
    write_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_point(32'sh7fffffff, 32'sh0, 32'sh80000000);
    send_point(32'sh00020000, 32'sh00030000, 32'shfffc0000);
    write_quat(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh0001);
    send_point(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
    send_point(32'sh40000000, 32'shc0000000, 32'sh40000000);

    // Random part: a new quaternion every fifty points, one of them zero,
    // with a calm stretch where neither side idles.
    for (int i = 0; i < 400; i++) begin
      if (i % 50 == 0) begin
        if (i == 300) write_quat('0, '0, '0, '0);
        else write_quat(random_quat_part(), random_quat_part(),
                        random_quat_part(), random_quat_part());
      end
      calm = (i >= 150 && i < 250);
      send_point(random_coord(), random_coord(), random_coord());
    end
    calm = 1'b0;

    drain();
    $display("Checked %0d rotated points over several quaternions, identity and zero included;",
             rotations.checked);
    $display("%0d results saturated and %0d flagged a zero norm.",
             rotations.sat_seen, rotations.zero_seen);
    if (rotations.mismatches == 0 && rotations.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
